// ===== hdl/mstt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mstt_pkg
// shared types and constants of the periodic timer table
// ----------------------------------------------------------------------------
package mstt_pkg;

	localparam int SLOTS         = 16;
	localparam int INTERVAL_BITS = 24;

	localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int IVL_W  = (INTERVAL_BITS < 24) ? INTERVAL_BITS : 24;
	localparam int ID_W   = 16;
	localparam int IN_IVL_W = 24;
	localparam int CNT_W  = 16;
	localparam int CTR_W  = 25;
	localparam int MODE_W = 2;
	localparam int ST_W   = 3;

	localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SET    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd3;

	localparam logic [ST_W-1:0] ST_ADDED    = 3'd0;
	localparam logic [ST_W-1:0] ST_UPDATED  = 3'd1;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd2;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
	localparam logic [ST_W-1:0] ST_FIRED    = 3'd4;
	localparam logic [ST_W-1:0] ST_OK       = 3'd5;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} mstt_cmd_t;

	typedef struct packed {
		logic idx_last;
	} mstt_stat_t;

endpackage
`default_nettype wire

// ===== hdl/mstt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mstt_ctrl
// sequencer: accepts an item, walks the slots, then finishes the item
// ----------------------------------------------------------------------------
module mstt_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	output mstt_pkg::mstt_cmd_t      cmd,
	input  wire mstt_pkg::mstt_stat_t stat
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t state_q;
	logic   busy_q;

	assign busy       = busy_q;
	assign cmd.load   = (state_q == S_IDLE) && start;
	assign cmd.step   = (state_q == S_SCAN);
	assign cmd.finish = (state_q == S_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SCAN;
						busy_q  <= 1'b1;
					end
				end
				S_SCAN: begin
					if (stat.idx_last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hdl/mstt_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mstt_dp
// slot storage, per-slot tick update, id search and result registers
// ----------------------------------------------------------------------------
module mstt_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire mstt_pkg::mstt_cmd_t            cmd,
	output mstt_pkg::mstt_stat_t                stat,
	input  wire logic [mstt_pkg::MODE_W-1:0]    mode,
	input  wire logic [mstt_pkg::ID_W-1:0]      req_id,
	input  wire logic [mstt_pkg::IN_IVL_W-1:0]  interval,
	input  wire logic [mstt_pkg::CNT_W-1:0]     repeat_count,
	input  wire logic                           resident,
	input  wire logic                           immediate,
	output logic                                strobe,
	output logic [mstt_pkg::ST_W-1:0]           status,
	output logic [mstt_pkg::ID_W-1:0]           result_id,
	output logic signed [mstt_pkg::CTR_W-1:0]   ticks_left,
	output logic [mstt_pkg::CNT_W-1:0]          count_left,
	output logic                                last
);

	localparam int N = mstt_pkg::SLOTS;

	logic [N-1:0]                        valid_q;
	logic [mstt_pkg::ID_W-1:0]           id_q   [N];
	logic [mstt_pkg::IVL_W-1:0]          ivl_q  [N];
	logic signed [mstt_pkg::CTR_W-1:0]   ctr_q  [N];
	logic [mstt_pkg::CNT_W-1:0]          cnt_q  [N];
	logic [N-1:0]                        res_q;
	logic [N-1:0]                        imm_q;

	logic [mstt_pkg::MODE_W-1:0]         mode_q;
	logic [mstt_pkg::ID_W-1:0]           rid_q;
	logic [mstt_pkg::IVL_W-1:0]          rivl_q;
	logic [mstt_pkg::CNT_W-1:0]          rcnt_q;
	logic                                rres_q;
	logic                                rimm_q;

	logic [mstt_pkg::IDX_W-1:0]          idx_q;
	logic                                found_q;
	logic [mstt_pkg::IDX_W-1:0]          fidx_q;
	logic                                free_q;
	logic [mstt_pkg::IDX_W-1:0]          freeidx_q;
	logic signed [mstt_pkg::CTR_W-1:0]   qctr_q;
	logic [mstt_pkg::CNT_W-1:0]          qcnt_q;
	logic                                pend_q;
	logic [mstt_pkg::ID_W-1:0]           pend_id_q;

	logic                                strobe_q;
	logic [mstt_pkg::ST_W-1:0]           status_q;
	logic [mstt_pkg::ID_W-1:0]           result_id_q;
	logic signed [mstt_pkg::CTR_W-1:0]   ticks_q;
	logic [mstt_pkg::CNT_W-1:0]          count_q;
	logic                                last_q;

	// tick update and id match of the slot under the scan index, and the write slot select
	logic signed [mstt_pkg::CTR_W-1:0]   dec_ctr;
	logic                                fire;
	logic signed [mstt_pkg::CTR_W-1:0]   new_ctr;
	logic [mstt_pkg::CNT_W-1:0]          new_cnt;
	logic                                keep;
	logic                                match;
	logic                                is_tick;
	logic [mstt_pkg::IDX_W-1:0]          wsel;

	assign is_tick = (mode_q == mstt_pkg::MODE_TICK);
	assign dec_ctr = imm_q[idx_q] ? '0 : ctr_q[idx_q] - mstt_pkg::CTR_W'(1);
	assign fire    = dec_ctr[mstt_pkg::CTR_W-1] || (dec_ctr == '0);
	assign new_ctr = fire ? mstt_pkg::CTR_W'(ivl_q[idx_q]) : dec_ctr;
	assign new_cnt = (fire && (cnt_q[idx_q] != '0)) ? cnt_q[idx_q] - mstt_pkg::CNT_W'(1)
	                                                : cnt_q[idx_q];
	assign keep    = res_q[idx_q] || (new_cnt != '0);
	assign match   = valid_q[idx_q] && (id_q[idx_q] == rid_q);
	assign wsel    = found_q ? fidx_q : freeidx_q;

	assign stat.idx_last = (idx_q == mstt_pkg::IDX_W'(N - 1));

	assign strobe     = strobe_q;
	assign status     = status_q;
	assign result_id  = result_id_q;
	assign ticks_left = ticks_q;
	assign count_left = count_q;
	assign last       = last_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			idx_q     <= '0;
			found_q   <= 1'b0;
			free_q    <= 1'b0;
			pend_q    <= 1'b0;
			strobe_q  <= 1'b0;
			mode_q    <= mstt_pkg::MODE_TICK;
		end else begin
			strobe_q <= 1'b0;
			if (cmd.load) begin
				mode_q  <= mode;
				idx_q   <= '0;
				found_q <= 1'b0;
				free_q  <= 1'b0;
				pend_q  <= 1'b0;
			end
			if (cmd.step) begin
				idx_q <= idx_q + mstt_pkg::IDX_W'(1);
				if (is_tick) begin
					if (valid_q[idx_q]) begin
						valid_q[idx_q] <= keep;
						if (fire) begin
							pend_q <= 1'b1;
							if (pend_q) begin
								strobe_q <= 1'b1;
							end
						end
					end
				end else begin
					if (match && !found_q) begin
						found_q <= 1'b1;
					end
					if (!valid_q[idx_q] && !free_q) begin
						free_q <= 1'b1;
					end
				end
			end
			if (cmd.finish) begin
				strobe_q <= 1'b1;
				unique case (mode_q)
					mstt_pkg::MODE_SET: begin
						if (found_q || free_q) begin
							valid_q[wsel] <= 1'b1;
						end
					end
					mstt_pkg::MODE_DELETE: begin
						if (found_q) begin
							valid_q[fidx_q] <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rid_q  <= req_id;
			rivl_q <= interval[mstt_pkg::IVL_W-1:0];
			rcnt_q <= repeat_count;
			rres_q <= resident;
			rimm_q <= immediate;
		end
		if (cmd.step) begin
			if (is_tick) begin
				if (valid_q[idx_q]) begin
					ctr_q[idx_q] <= new_ctr;
					cnt_q[idx_q] <= new_cnt;
					imm_q[idx_q] <= 1'b0;
					if (fire) begin
						pend_id_q   <= id_q[idx_q];
						status_q    <= mstt_pkg::ST_FIRED;
						result_id_q <= pend_id_q;
						ticks_q     <= '0;
						count_q     <= '0;
						last_q      <= 1'b0;
					end
				end
			end else begin
				if (match && !found_q) begin
					fidx_q <= idx_q;
					qctr_q <= ctr_q[idx_q];
					qcnt_q <= cnt_q[idx_q];
				end
				if (!valid_q[idx_q] && !free_q) begin
					freeidx_q <= idx_q;
				end
			end
		end
		if (cmd.finish) begin
			last_q      <= 1'b1;
			ticks_q     <= '0;
			count_q     <= '0;
			result_id_q <= rid_q;
			unique case (mode_q)
				mstt_pkg::MODE_TICK: begin
					if (pend_q) begin
						status_q    <= mstt_pkg::ST_FIRED;
						result_id_q <= pend_id_q;
					end else begin
						status_q    <= mstt_pkg::ST_OK;
						result_id_q <= '0;
					end
				end
				mstt_pkg::MODE_SET: begin
					if (found_q || free_q) begin
						status_q     <= found_q ? mstt_pkg::ST_UPDATED : mstt_pkg::ST_ADDED;
						id_q[wsel]   <= rid_q;
						ivl_q[wsel]  <= rivl_q;
						ctr_q[wsel]  <= mstt_pkg::CTR_W'(rivl_q);
						cnt_q[wsel]  <= rcnt_q;
						res_q[wsel]  <= rres_q;
						imm_q[wsel]  <= rimm_q;
					end else begin
						status_q <= mstt_pkg::ST_FULL;
					end
				end
				mstt_pkg::MODE_DELETE: begin
					status_q <= found_q ? mstt_pkg::ST_OK : mstt_pkg::ST_NOTFOUND;
				end
				mstt_pkg::MODE_QUERY: begin
					if (found_q) begin
						status_q <= mstt_pkg::ST_OK;
						ticks_q  <= qctr_q;
						count_q  <= qcnt_q;
					end else begin
						status_q <= mstt_pkg::ST_NOTFOUND;
					end
				end
				default: begin
					status_q <= mstt_pkg::ST_OK;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hdl/multi_slot_periodic_timer_table_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_slot_periodic_timer_table_core
// table of periodic timer slots with set, delete, query and tick requests
//
//  channel   handshake           payload
//  request   start / busy        mode req_id interval repeat_count
//                                resident immediate
//  result    strobe (1 cycle)    status result_id ticks_left count_left last
//
// every item is accepted, then walks over the slots, one slot per cycle,
// then is finished; busy is high from the accept to the end.
// a tick gives one result per firing slot, spaced by the walk, or one quiet
// result; other requests give one result in the finishing state.
// reset clears all slots to free; results cannot be stalled.
// ----------------------------------------------------------------------------
module multi_slot_periodic_timer_table_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [mstt_pkg::MODE_W-1:0]    mode,
	input  wire logic [mstt_pkg::ID_W-1:0]      req_id,
	input  wire logic [mstt_pkg::IN_IVL_W-1:0]  interval,
	input  wire logic [mstt_pkg::CNT_W-1:0]     repeat_count,
	input  wire logic                           resident,
	input  wire logic                           immediate,
	output logic                                strobe,
	output logic [mstt_pkg::ST_W-1:0]           status,
	output logic [mstt_pkg::ID_W-1:0]           result_id,
	output logic signed [mstt_pkg::CTR_W-1:0]   ticks_left,
	output logic [mstt_pkg::CNT_W-1:0]          count_left,
	output logic                                last
);

	mstt_pkg::mstt_cmd_t  cmd;
	mstt_pkg::mstt_stat_t stat;

	mstt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.stat   (stat)
	);

	mstt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.mode         (mode),
		.req_id       (req_id),
		.interval     (interval),
		.repeat_count (repeat_count),
		.resident     (resident),
		.immediate    (immediate),
		.strobe       (strobe),
		.status       (status),
		.result_id    (result_id),
		.ticks_left   (ticks_left),
		.count_left   (count_left),
		.last         (last)
	);

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// timer table checker: directed and random set, delete, query and tick
// requests, every result compared field by field with a software timer table
// ----------------------------------------------------------------------------
module tb_top;
	import mstt_pkg::*;

	typedef struct {
		logic [ST_W-1:0]  st;
		logic [ID_W-1:0]  id;
		logic [CTR_W-1:0] ticks;
		logic [CNT_W-1:0] cnt;
		logic             lst;
	} timer_res_t;

	class timer_scoreboard;
		bit              valid [SLOTS];
		bit [ID_W-1:0]   tid [SLOTS];
		longint          ivl [SLOTS];
		longint          ctr [SLOTS];
		int              cnt [SLOTS];
		bit              res [SLOTS];
		bit              imm [SLOTS];
		timer_res_t      expected_q[$];
		int              errors;

		function void put(logic [ST_W-1:0] st, logic [ID_W-1:0] id, longint t, int c, bit l);
			timer_res_t r;
			r.st = st; r.id = id; r.ticks = t[CTR_W-1:0]; r.cnt = c[CNT_W-1:0]; r.lst = l;
			expected_q.push_back(r);
		endfunction

		function int lookup(logic [ID_W-1:0] id);
			for (int i = 0; i < SLOTS; i++)
				if (valid[i] && tid[i] == id) return i;
			return -1;
		endfunction

		function void note_item(logic [MODE_W-1:0] m, logic [ID_W-1:0] id,
				logic [IN_IVL_W-1:0] iv, logic [CNT_W-1:0] rc, bit r, bit im);
			int s;
			int n;
			logic [ST_W-1:0] st;
			s = lookup(id);
			n = 0;
			case (m)
				MODE_SET: begin
					st = ST_UPDATED;
					if (s < 0) begin
						st = ST_ADDED;
						for (int i = SLOTS - 1; i >= 0; i--)
							if (!valid[i]) s = i;
					end
					if (s < 0) begin
						put(ST_FULL, id, 0, 0, 1);
					end else begin
						valid[s] = 1; tid[s] = id;
						ivl[s] = iv & ((64'd1 << IVL_W) - 1);
						ctr[s] = ivl[s]; cnt[s] = rc; res[s] = r; imm[s] = im;
						put(st, id, 0, 0, 1);
					end
				end
				MODE_DELETE: begin
					if (s < 0) begin
						put(ST_NOTFOUND, id, 0, 0, 1);
					end else begin
						valid[s] = 0;
						put(ST_OK, id, 0, 0, 1);
					end
				end
				MODE_QUERY: begin
					if (s < 0) put(ST_NOTFOUND, id, 0, 0, 1);
					else put(ST_OK, id, ctr[s], cnt[s], 1);
				end
				default: begin
					for (int i = 0; i < SLOTS; i++) begin
						if (!valid[i]) continue;
						if (imm[i]) begin
							ctr[i] = 0; imm[i] = 0;
						end else begin
							ctr[i] -= 1;
						end
						if (ctr[i] <= 0) begin
							ctr[i] = ivl[i];
							if (cnt[i] > 0) cnt[i] -= 1;
							put(ST_FIRED, tid[i], 0, 0, 0);
							n++;
						end
						if (!res[i] && cnt[i] == 0) valid[i] = 0;
					end
					if (n == 0) put(ST_OK, 0, 0, 0, 1);
					else expected_q[$].lst = 1;
				end
			endcase
		endfunction

		function void check_result(timer_res_t a);
			timer_res_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result st=%0d id=%0d", $time, a.st, a.id);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (a.st !== e.st)
				$display("%0t: status exp %0d got %0d", $time, e.st, a.st);
			if (a.id !== e.id)
				$display("%0t: result_id exp %0d got %0d", $time, e.id, a.id);
			if (a.ticks !== e.ticks)
				$display("%0t: ticks_left exp %0h got %0h", $time, e.ticks, a.ticks);
			if (a.cnt !== e.cnt)
				$display("%0t: count_left exp %0d got %0d", $time, e.cnt, a.cnt);
			if (a.lst !== e.lst)
				$display("%0t: last exp %0d got %0d", $time, e.lst, a.lst);
			if (a.st !== e.st || a.id !== e.id || a.ticks !== e.ticks || a.cnt !== e.cnt
					|| a.lst !== e.lst)
				errors++;
		endfunction
	endclass

	logic                clk = 0;
	logic                arst_n = 0;
	logic                start = 0;
	logic [MODE_W-1:0]   mode = MODE_TICK;
	logic [ID_W-1:0]     req_id = 0;
	logic [IN_IVL_W-1:0] interval = 0;
	logic [CNT_W-1:0]    repeat_count = 0;
	logic                resident = 0;
	logic                immediate = 0;
	wire                 busy, strobe, last;
	wire [ST_W-1:0]      status;
	wire [ID_W-1:0]      result_id;
	wire signed [CTR_W-1:0] ticks_left;
	wire [CNT_W-1:0]     count_left;

	timer_scoreboard sb = new();
	bit idling = 1;

	always #6 clk = ~clk;

	multi_slot_periodic_timer_table_core dut (.*);

	always @(posedge clk) begin
		timer_res_t a;
		if (arst_n && start && !busy)
			sb.note_item(mode, req_id, interval, repeat_count, resident, immediate);
		if (arst_n && strobe) begin
			a.st = status; a.id = result_id; a.ticks = ticks_left;
			a.cnt = count_left; a.lst = last;
			sb.check_result(a);
		end
	end

	task automatic send_item(logic [MODE_W-1:0] m, logic [ID_W-1:0] id,
			logic [IN_IVL_W-1:0] iv, logic [CNT_W-1:0] rc, bit r, bit im);
		if (idling && $urandom_range(0, 3) == 0) begin
			start <= 0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		start <= 1; mode <= m; req_id <= id; interval <= iv;
		repeat_count <= rc; resident <= r; immediate <= im;
		do @(negedge clk); while (busy);
		@(posedge clk);
	endtask

	task automatic drain();
		start <= 0;
		@(negedge clk);
		while (sb.expected_q.size() != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic random_item();
		int sel;
		logic [ID_W-1:0] id;
		logic [IN_IVL_W-1:0] iv;
		logic [CNT_W-1:0] rc;
		sel = $urandom_range(0, 9);
		id = ($urandom_range(0, 7) == 0) ? ID_W'($urandom_range(0, 65535))
		                                 : ID_W'($urandom_range(0, 19));
		iv = ($urandom_range(0, 9) == 0) ? IN_IVL_W'($urandom_range(0, 24'hFFFFFF))
		                                 : IN_IVL_W'($urandom_range(0, 6));
		rc = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom_range(0, 65535))
		                                 : CNT_W'($urandom_range(0, 4));
		send_item(sel < 4 ? MODE_TICK : sel < 7 ? MODE_SET : sel < 8 ? MODE_DELETE : MODE_QUERY,
			id, iv, rc, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_item(MODE_TICK, 0, 0, 0, 0, 0);
		send_item(MODE_SET, 16'd0, 24'd0, 16'd1, 0, 0);
		send_item(MODE_SET, 16'hFFFF, 24'hFFFFFF, 16'hFFFF, 1, 1);
		send_item(MODE_QUERY, 16'hFFFF, 0, 0, 0, 0);
		send_item(MODE_TICK, 0, 0, 0, 0, 0);
		send_item(MODE_QUERY, 16'hFFFF, 0, 0, 0, 0);
		send_item(MODE_QUERY, 16'd0, 0, 0, 0, 0);
		send_item(MODE_SET, 16'hFFFF, 24'd2, 16'd0, 1, 0);
		send_item(MODE_SET, 16'd7, 24'd1, 16'd0, 0, 0);
		send_item(MODE_TICK, 0, 0, 0, 0, 0);
		send_item(MODE_TICK, 0, 0, 0, 0, 0);
		for (int i = 0; i < 16; i++)
			send_item(MODE_SET, 16'(100 + i), 24'(i), 16'(3), 1, 0);
		send_item(MODE_DELETE, 16'd100, 0, 0, 0, 0);
		send_item(MODE_DELETE, 16'd100, 0, 0, 0, 0);
		send_item(MODE_TICK, 0, 0, 0, 0, 0);
		drain();
		for (int i = 0; i < 16; i++)
			send_item(MODE_DELETE, 16'(100 + i), 0, 0, 0, 0);
		for (int k = 0; k < 214; k++) begin
			if (k == 120) drain();
			if (k == 180) idling = 0;
			random_item();
		end
		drain();
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		#3ms;
		$display("tb_top: done, errors");
		$finish;
	end
endmodule

// ===== multi_slot_periodic_timer_table_core.f =====
hdl/mstt_pkg.sv
hdl/mstt_ctrl.sv
hdl/mstt_dp.sv
hdl/multi_slot_periodic_timer_table_core.sv
verif/tb_top.sv
